>>> src/urig_pkg.sv
// Shared constants, types and controller/datapath interface structs for the index generator.
package urig_pkg;

    localparam int DRAW_W      = 64;
    localparam int HALF_W      = DRAW_W / 2;
    localparam int INDEX_W     = 6;
    localparam int NUM_CHOICES = 48;

    localparam logic [DRAW_W-1:0] WEYL_STEP  = 64'h9e37_79b9_7f4a_7c15;
    localparam int                MIX_SHIFT  = 17;
    localparam int                ROT_AMOUNT = 32;

    // Draws at or above this value are rejected so the reduction stays unbiased.
    localparam logic [DRAW_W-1:0] DRAW_MAX = {DRAW_W{1'b1}};
    localparam logic [DRAW_W-1:0] LIMIT    =
        DRAW_MAX - (DRAW_MAX % DRAW_W'(NUM_CHOICES));

    // 48 = 3 << 4: the low 4 bits pass through, the upper bits are reduced
    // mod 3 by folding 16-bit chunks (2^16 = 1 mod 3).
    localparam int MOD_LOW_W = 4;
    localparam int FOLD_W    = 16;
    localparam int SUM_W     = FOLD_W + 2;
    localparam int REM_W     = INDEX_W;

    // Fold happens with the rejection check, the finish in the S_MOD state.
    localparam int MOD_STEPS = 1;
    localparam int CNT_W     = 2;

    localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(MOD_STEPS - 1);

    // 64x64 low-half product built from three 32x32 partial products.
    typedef enum logic [1:0] {
        MUL_LL = 2'd0,
        MUL_HL = 2'd1,
        MUL_LH = 2'd2
    } t_mul_step;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_LH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ADV   = 8'b0000_0010,
        S_MUL1  = 8'b0000_0100,
        S_ROT   = 8'b0000_1000,
        S_MUL2  = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_MOD   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic      advance;
        logic      mul_en;
        t_mul_step mul_step;
        logic      remix;
        logic      mod_init;
        logic      mod_step;
        logic      load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic reject;
        logic out_free;
    } t_dp_status;

endpackage

>>> src/unbiased_random_index_generator_top.sv
// Top level of the unbiased random index generator: controller plus datapath.
//
// Request channel: i_valid / o_stall with i_draw_request. A request is taken
// on a clock edge with i_valid high and o_stall low. A request whose bit is 0
// is taken and produces no result.
// Result channel: o_valid / i_stall with o_chosen_index and o_raw_draw; a
// result is taken on an edge with o_valid high and i_stall low.
// Seed: i_seed_we loads i_seed_value into the generator state; write it only
// while no request is in flight.
// A request runs: advance, first multiply, remix, second multiply, rejection
// check; a rejected draw goes back to advance. Each 64-bit multiply is
// three passes through one shared 32x32 multiplier, and the modulo unit
// folds the draw during the check and finishes in the next cycle.
// One request is worked on at a time; o_stall is high from the cycle after a
// request with its bit set is taken until its result sits in the output
// register, which lets a new request start while it waits.
// When the receiver stalls with a result held and the next draw finishes,
// the block waits with o_stall high until the output register frees up.
// Reset (synchronous, active low) clears the state to 0 and empties the output.
module unbiased_random_index_generator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_seed_we,
    input  logic [urig_pkg::DRAW_W-1:0]        i_seed_value,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_draw_request,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [urig_pkg::INDEX_W-1:0]       o_chosen_index,
    output logic [urig_pkg::DRAW_W-1:0]        o_raw_draw
);

    urig_pkg::t_dp_cmd    cmd;
    urig_pkg::t_dp_status status;

    urig_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_draw_request (i_draw_request),
        .o_stall        (o_stall),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    urig_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_we      (i_seed_we),
        .i_seed_value   (i_seed_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_chosen_index (o_chosen_index),
        .o_raw_draw     (o_raw_draw)
    );

endmodule

>>> src/urig_ctrl.sv
// Sequencer for one draw: advance, two multiplies, rejection check, folded modulo.
module urig_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_draw_request,
    output logic                  o_stall,
    input  urig_pkg::t_dp_status  i_status,
    output urig_pkg::t_dp_cmd     o_cmd
);

    urig_pkg::t_state           r_state, n_state;
    logic [urig_pkg::CNT_W-1:0] r_cnt, n_cnt;

    assign o_stall = (r_state != urig_pkg::S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.mul_step = urig_pkg::t_mul_step'(r_cnt[1:0]);
        case (r_state)
            urig_pkg::S_IDLE: begin
                // a request with the bit clear is taken and dropped
                if (i_valid && i_draw_request) begin
                    n_state = urig_pkg::S_ADV;
                end
            end
            urig_pkg::S_ADV: begin
                o_cmd.advance = 1'b1;
                n_cnt         = '0;
                n_state       = urig_pkg::S_MUL1;
            end
            urig_pkg::S_MUL1: begin
                o_cmd.mul_en = 1'b1;
                if (r_cnt == urig_pkg::MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = urig_pkg::S_ROT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            urig_pkg::S_ROT: begin
                o_cmd.remix = 1'b1;
                n_cnt       = '0;
                n_state     = urig_pkg::S_MUL2;
            end
            urig_pkg::S_MUL2: begin
                o_cmd.mul_en = 1'b1;
                if (r_cnt == urig_pkg::MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = urig_pkg::S_CHECK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            urig_pkg::S_CHECK: begin
                if (i_status.reject) begin
                    n_state = urig_pkg::S_ADV;
                end else begin
                    o_cmd.mod_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = urig_pkg::S_MOD;
                end
            end
            urig_pkg::S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (r_cnt == urig_pkg::MOD_LAST) begin
                    n_cnt   = '0;
                    n_state = urig_pkg::S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            urig_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = urig_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = urig_pkg::S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= urig_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> src/urig_dp.sv
// Datapath: Weyl state, shared 32x32 multiplier, rejection compare, modulo and output register.
module urig_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_seed_we,
    input  logic [urig_pkg::DRAW_W-1:0]       i_seed_value,
    input  urig_pkg::t_dp_cmd                 i_cmd,
    output urig_pkg::t_dp_status              o_status,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [urig_pkg::INDEX_W-1:0]      o_chosen_index,
    output logic [urig_pkg::DRAW_W-1:0]       o_raw_draw
);

    localparam int DW = urig_pkg::DRAW_W;
    localparam int HW = urig_pkg::HALF_W;
    localparam int RW = urig_pkg::REM_W;
    localparam int FW = urig_pkg::FOLD_W;
    localparam int SW = urig_pkg::SUM_W;
    localparam int LW = urig_pkg::MOD_LOW_W;

    logic [DW-1:0]          r_gen;
    logic [DW-1:0]          r_mop;
    logic [DW-1:0]          r_acc;
    logic [SW-1:0]          r_fold;
    logic [RW-1:0]          r_rem;
    logic                   r_out_valid;
    logic [urig_pkg::INDEX_W-1:0] r_out_idx;
    logic [DW-1:0]          r_out_raw;

    logic [DW-1:0] gen_next;
    logic [DW-1:0] z_rot;
    logic [HW-1:0] mul_a;
    logic [HW-1:0] mul_b;
    logic [DW-1:0] prod;
    logic [DW-LW-1:0] mod_hi;
    logic [SW-1:0] fold_next;
    logic [RW-1:0] rem_next;

    assign gen_next = r_gen + urig_pkg::WEYL_STEP;
    assign z_rot    = {r_acc[DW-urig_pkg::ROT_AMOUNT-1:0], r_acc[DW-1:DW-urig_pkg::ROT_AMOUNT]};

    // low half of a 64x64 product: lo*lo, then the two cross terms shifted up
    always_comb begin
        case (i_cmd.mul_step)
            urig_pkg::MUL_LL: begin
                mul_a = r_mop[HW-1:0];
                mul_b = urig_pkg::WEYL_STEP[HW-1:0];
            end
            urig_pkg::MUL_HL: begin
                mul_a = r_mop[DW-1:HW];
                mul_b = urig_pkg::WEYL_STEP[HW-1:0];
            end
            urig_pkg::MUL_LH: begin
                mul_a = r_mop[HW-1:0];
                mul_b = urig_pkg::WEYL_STEP[DW-1:HW];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // draw mod 48 = 16 * ((draw >> 4) mod 3) + draw[3:0]
    assign mod_hi    = r_acc[DW-1:LW];
    assign fold_next = SW'(mod_hi[FW-1:0]) + SW'(mod_hi[2*FW-1:FW]) +
                       SW'(mod_hi[3*FW-1:2*FW]) + SW'(mod_hi[DW-LW-1:3*FW]);

    // keep folding the sum in 8, 4 and 2 bit chunks, then at most two subtracts
    always_comb begin
        logic [9:0] f2;
        logic [5:0] f3;
        logic [3:0] f4;
        f2 = 10'(r_fold[7:0]) + 10'(r_fold[15:8]) + 10'(r_fold[SW-1:16]);
        f3 = 6'(f2[3:0]) + 6'(f2[7:4]) + 6'(f2[9:8]);
        f4 = 4'(f3[1:0]) + 4'(f3[3:2]) + 4'(f3[5:4]);
        if (f4 >= 4'd6) begin
            f4 = f4 - 4'd6;
        end
        if (f4 >= 4'd3) begin
            f4 = f4 - 4'd3;
        end
        rem_next = {f4[1:0], r_acc[LW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= '0;
        end else if (i_seed_we) begin
            r_gen <= i_seed_value;
        end else if (i_cmd.advance) begin
            r_gen <= gen_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            r_mop <= gen_next ^ (gen_next >> urig_pkg::MIX_SHIFT);
        end else if (i_cmd.remix) begin
            r_mop <= r_gen ^ z_rot ^ (z_rot >> urig_pkg::MIX_SHIFT);
        end

        if (i_cmd.mul_en) begin
            if (i_cmd.mul_step == urig_pkg::MUL_LL) begin
                r_acc <= prod;
            end else begin
                r_acc <= r_acc + {prod[HW-1:0], {HW{1'b0}}};
            end
        end

        if (i_cmd.mod_init) begin
            r_fold <= fold_next;
        end

        if (i_cmd.mod_step) begin
            r_rem <= rem_next;
        end

        if (i_cmd.load_out) begin
            r_out_idx <= r_rem[urig_pkg::INDEX_W-1:0];
            r_out_raw <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.reject   = (r_acc >= urig_pkg::LIMIT);
    assign o_status.out_free = !r_out_valid || !i_stall;

    assign o_valid        = r_out_valid;
    assign o_chosen_index = r_out_idx;
    assign o_raw_draw     = r_out_raw;

endmodule

>>> sim/unbiased_random_index_generator_top_test.sv
// Self-checking testbench for the unbiased random index generator top level.
`timescale 1ns / 100ps

module unbiased_random_index_generator_top_test;

    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RAND_PHASES    = 5;
    localparam int RAND_ITEMS     = 130;

    localparam int DW = urig_pkg::DRAW_W;
    localparam int IW = urig_pkg::INDEX_W;

    typedef struct packed {
        logic [IW-1:0] index;
        logic [DW-1:0] raw;
    } t_draw_result;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE   = 2'd0,
        STALL_LIGHT  = 2'd1,
        STALL_HEAVY  = 2'd2,
        STALL_TOGGLE = 2'd3
    } t_stall_mode;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_seed_we      = 1'b0;
    logic [DW-1:0]      i_seed_value   = '0;
    logic               i_valid        = 1'b0;
    logic               i_draw_request = 1'b0;
    logic               i_stall        = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [IW-1:0]      o_chosen_index;
    logic [DW-1:0]      o_raw_draw;

    logic         pending_requests[$];
    t_draw_result expected_draws[$];
    logic [DW-1:0] gen_state = '0;
    int error_count  = 0;
    int results_seen = 0;

    unbiased_random_index_generator_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_we      (i_seed_we),
        .i_seed_value   (i_seed_value),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_draw_request (i_draw_request),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_chosen_index (o_chosen_index),
        .o_raw_draw     (o_raw_draw)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output mixer applied to one advanced Weyl state.
    function automatic logic [DW-1:0] mix_state(input logic [DW-1:0] s);
        logic [DW-1:0] z;
        z = urig_pkg::WEYL_STEP * (s ^ (s >> urig_pkg::MIX_SHIFT));
        z = (z << urig_pkg::ROT_AMOUNT) | (z >> (DW - urig_pkg::ROT_AMOUNT));
        return urig_pkg::WEYL_STEP * (s ^ z ^ (z >> urig_pkg::MIX_SHIFT));
    endfunction

    // Draw until one falls below the rejection limit, then reduce it.
    task automatic predict_draw();
        t_draw_result  res;
        logic [DW-1:0] draw;
        logic [DW-1:0] reduced;
        do begin
            gen_state = gen_state + urig_pkg::WEYL_STEP;
            draw      = mix_state(gen_state);
        end while (draw >= urig_pkg::LIMIT);
        reduced   = draw % DW'(urig_pkg::NUM_CHOICES);
        res.index = reduced[IW-1:0];
        res.raw   = draw;
        expected_draws.push_back(res);
    endtask

    // Driver: bursts of requests separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        logic accepted;
        logic offer;
        logic req_bit;
        accepted = i_rst_n && i_valid && !o_stall;
        offer    = 1'b0;
        req_bit  = 1'b0;
        if (accepted && i_draw_request) begin
            predict_draw();
        end
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !accepted)) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_requests.size() > 0) begin
                offer   = 1'b1;
                req_bit = pending_requests.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            i_valid <= offer;
            if (offer) begin
                i_draw_request <= req_bit;
            end
        end
    end

    // Receiver: segments of random stall patterns plus one long hold-off.
    int          seg_left  = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    t_stall_mode stall_mode = STALL_NONE;

    always @(posedge i_clk) begin
        logic stall_next;
        stall_next = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            stall_next = 1'b1;
        end else begin
            if (seg_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                seg_left   = $urandom_range(1, 60);
            end
            seg_left--;
            case (stall_mode)
                STALL_NONE:   stall_next = 1'b0;
                STALL_LIGHT:  stall_next = ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  stall_next = ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: stall_next = ~i_stall;
                default:      stall_next = 1'b0;
            endcase
        end
        i_stall <= stall_next;
    end

    // Monitor and watchdog.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        t_draw_result want;
        logic         out_accept;
        out_accept = i_rst_n && o_valid && !i_stall;
        if (out_accept) begin
            results_seen++;
            if (expected_draws.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result index=%0d raw=%h",
                         $time, o_chosen_index, o_raw_draw);
            end else begin
                want = expected_draws.pop_front();
                if (o_chosen_index !== want.index) begin
                    error_count++;
                    $display("%0t: chosen_index expected %0d actual %0d",
                             $time, want.index, o_chosen_index);
                end
                if (o_raw_draw !== want.raw) begin
                    error_count++;
                    $display("%0t: raw_draw expected %h actual %h",
                             $time, want.raw, o_raw_draw);
                end
            end
        end
        if (!i_rst_n || out_accept || i_seed_we || (i_valid && !o_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("unbiased_random_index_generator_top test failed");
                $finish;
            end
        end
    end

    task automatic write_seed(input logic [DW-1:0] value);
        @(posedge i_clk);
        i_seed_we    <= 1'b1;
        i_seed_value <= value;
        gen_state     = value;
        @(posedge i_clk);
        i_seed_we    <= 1'b0;
    endtask

    // Sender pause: nothing queued, nothing offered, nothing outstanding.
    task automatic wait_drained();
        while (pending_requests.size() > 0 || i_valid || expected_draws.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_requests(input logic [31:0] bits, input int count);
        @(negedge i_clk);
        for (int k = 0; k < count; k++) begin
            pending_requests.push_back(bits[k]);
        end
    endtask

    task automatic queue_random(input int count);
        @(negedge i_clk);
        for (int k = 0; k < count; k++) begin
            // mostly real requests, some empty ones
            pending_requests.push_back($urandom_range(0, 9) != 0);
        end
    endtask

    initial begin
        logic [DW-1:0] seed;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset state, then extreme and edge seeds.
        queue_requests(32'b1101, 4);
        wait_drained();
        write_seed({DW{1'b1}});
        queue_requests(32'b1011, 4);
        wait_drained();
        write_seed('0);
        queue_requests(32'b111, 3);
        wait_drained();
        write_seed({1'b1, {(DW-1){1'b0}}});
        queue_requests(32'b11, 2);
        wait_drained();
        write_seed({1'b0, {(DW-1){1'b1}}});
        queue_requests(32'b11, 2);
        wait_drained();

        // Random phases, each with its own seed.
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                1:       seed = {DW{1'b1}};
                3:       seed = '0;
                default: seed = {$urandom, $urandom};
            endcase
            write_seed(seed);
            queue_random(RAND_ITEMS);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("unbiased_random_index_generator_top test passed");
        end else begin
            $display("unbiased_random_index_generator_top test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/urig_pkg.sv
src/urig_ctrl.sv
src/urig_dp.sv
src/unbiased_random_index_generator_top.sv
sim/unbiased_random_index_generator_top_test.sv
